// ----- hw/rtl/pidf_pkg.sv -----
// pidf_pkg: widths, codes, state encoding and the structs shared by the
// filtered-derivative PID core. Depends on nothing.
`timescale 1ns / 1ps

package pidf_pkg;

	localparam int DATA_W       = 32;
	localparam int FRAC_BITS    = 16;
	localparam int FILTER_SHIFT = 16;
	localparam int GAIN_W       = 32;
	localparam int HALF_W       = GAIN_W / 2;
	localparam int BOUND_W      = 31;
	localparam int WEIGHT_W     = 17;
	localparam int ERR_W        = DATA_W + 1;
	localparam int DIFF_W       = DATA_W + 2;
	localparam int MUL_A_W      = DIFF_W;
	localparam int MUL_B_W      = WEIGHT_W + 1;
	localparam int PROD_W       = MUL_A_W + MUL_B_W;
	localparam int ACC_W        = PROD_W + HALF_W;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [WEIGHT_W-1:0] FILTER_ONE = WEIGHT_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P,
		REG_GAIN_I,
		REG_GAIN_D,
		REG_INT_BOUND,
		REG_DRIVE_BOUND,
		REG_FILTER_WEIGHT,
		REG_DERIV_BOUND
	} cfg_reg_t;

	// multiplier passes, in issue order
	typedef enum logic [2:0] {
		MS_DIFF_W,
		MS_PREVD_WC,
		MS_ERR_PLO,
		MS_ERR_PHI,
		MS_INT_ILO,
		MS_INT_IHI,
		MS_DER_DLO,
		MS_DER_DHI
	} mul_step_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_INTEG,
		ST_MUL,
		ST_MWAIT,
		ST_DERIV,
		ST_DRIVE
	} state_t;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [BOUND_W-1:0]  int_bound;
		logic [BOUND_W-1:0]  drive_bound;
		logic [WEIGHT_W-1:0] filter_weight;
		logic [BOUND_W-1:0]  deriv_bound;
	} cfg_t;

	typedef struct packed {
		logic      latch;
		logic      clear;
		logic      integ;
		logic      mul;
		mul_step_t step;
		logic      deriv;
		logic      drive;
	} cmd_t;

endpackage

// ----- hw/rtl/pidf_cfg.sv -----
// pidf_cfg: configuration register file for the PID core.
// Depends on pidf_pkg.
`timescale 1ns / 1ps

module pidf_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pidf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidf_pkg::CFG_DATA_W-1:0]      cfg_data,
	output pidf_pkg::cfg_t                       cfg
);

	pidf_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pidf_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data[pidf_pkg::GAIN_W-1:0];
				end
				pidf_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data[pidf_pkg::GAIN_W-1:0];
				end
				pidf_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data[pidf_pkg::GAIN_W-1:0];
				end
				pidf_pkg::REG_INT_BOUND: begin
					cfg_q.int_bound <= cfg_data[pidf_pkg::BOUND_W-1:0];
				end
				pidf_pkg::REG_DRIVE_BOUND: begin
					cfg_q.drive_bound <= cfg_data[pidf_pkg::BOUND_W-1:0];
				end
				pidf_pkg::REG_FILTER_WEIGHT: begin
					// weights above unity act as unity
					if (cfg_data[pidf_pkg::WEIGHT_W-1:0] > pidf_pkg::FILTER_ONE)
						cfg_q.filter_weight <= pidf_pkg::FILTER_ONE;
					else
						cfg_q.filter_weight <= cfg_data[pidf_pkg::WEIGHT_W-1:0];
				end
				pidf_pkg::REG_DERIV_BOUND: begin
					cfg_q.deriv_bound <= cfg_data[pidf_pkg::BOUND_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/pidf_ctrl.sv -----
// pidf_ctrl: sequencer for the PID core; issues datapath commands and owns
// the input and result handshakes. Depends on pidf_pkg.
`timescale 1ns / 1ps

module pidf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic                 operation,
	output logic                 result_valid,
	input  logic                 result_stall,
	output pidf_pkg::cmd_t       cmd
);

	pidf_pkg::state_t    state_q;
	pidf_pkg::state_t    state_d;
	pidf_pkg::mul_step_t step_q;
	logic                result_valid_q;
	logic                accept;
	logic                out_free;

	assign accept       = sample_valid && (state_q == pidf_pkg::ST_IDLE);
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pidf_pkg::ST_IDLE: begin
				if (accept)
					state_d = operation ? pidf_pkg::ST_CLEAR : pidf_pkg::ST_INTEG;
			end
			pidf_pkg::ST_CLEAR: begin
				if (out_free)
					state_d = pidf_pkg::ST_IDLE;
			end
			pidf_pkg::ST_INTEG: begin
				state_d = pidf_pkg::ST_MUL;
			end
			pidf_pkg::ST_MUL: begin
				if (step_q == pidf_pkg::MS_PREVD_WC || step_q == pidf_pkg::MS_DER_DHI)
					state_d = pidf_pkg::ST_MWAIT;
			end
			pidf_pkg::ST_MWAIT: begin
				// step already advanced past the last issued pass
				if (step_q == pidf_pkg::MS_ERR_PLO)
					state_d = pidf_pkg::ST_DERIV;
				else
					state_d = pidf_pkg::ST_DRIVE;
			end
			pidf_pkg::ST_DERIV: begin
				state_d = pidf_pkg::ST_MUL;
			end
			pidf_pkg::ST_DRIVE: begin
				if (out_free)
					state_d = pidf_pkg::ST_IDLE;
			end
			default: begin
				state_d = pidf_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		sample_stall = (state_q != pidf_pkg::ST_IDLE);
		cmd.latch    = accept;
		cmd.clear    = (state_q == pidf_pkg::ST_CLEAR) && out_free;
		cmd.integ    = (state_q == pidf_pkg::ST_INTEG);
		cmd.mul      = (state_q == pidf_pkg::ST_MUL);
		cmd.step     = step_q;
		cmd.deriv    = (state_q == pidf_pkg::ST_DERIV);
		cmd.drive    = (state_q == pidf_pkg::ST_DRIVE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pidf_pkg::ST_IDLE;
			step_q         <= pidf_pkg::MS_DIFF_W;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pidf_pkg::ST_MUL)
				step_q <= pidf_pkg::mul_step_t'(3'(step_q + 3'd1));
			if (cmd.drive || cmd.clear)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

endmodule

// ----- hw/rtl/pidf_dp.sv -----
// pidf_dp: PID datapath - error, clamped integral, shared 34x18 multiplier
// with accumulator, filtered derivative and output saturation. Depends on pidf_pkg.
`timescale 1ns / 1ps

module pidf_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pidf_pkg::cfg_t                       cfg,
	input  pidf_pkg::cmd_t                       cmd,
	input  logic signed [pidf_pkg::DATA_W-1:0]   reference,
	input  logic signed [pidf_pkg::DATA_W-1:0]   feedback,
	output logic signed [pidf_pkg::DATA_W-1:0]   drive,
	output logic                                 saturated
);

	localparam int DW = pidf_pkg::DATA_W;
	localparam int AW = pidf_pkg::ACC_W;

	logic signed [pidf_pkg::ERR_W-1:0]    err_q;
	logic signed [pidf_pkg::ERR_W-1:0]    prev_err_q;
	logic signed [pidf_pkg::DIFF_W-1:0]   diff_q;
	logic signed [DW-1:0]                 integ_q;
	logic signed [DW-1:0]                 prev_d_q;
	logic signed [DW-1:0]                 drive_q;
	logic                                 sat_q;
	logic                                 int_en_q;
	logic signed [pidf_pkg::MUL_A_W-1:0]  mul_a;
	logic signed [pidf_pkg::MUL_B_W-1:0]  mul_b;
	logic signed [pidf_pkg::PROD_W-1:0]   prod_s1;
	logic                                 acc_en_s1;
	logic                                 shift_s1;
	logic signed [AW-1:0]                 acc_q;
	logic signed [AW-1:0]                 addend;
	logic [pidf_pkg::WEIGHT_W-1:0]        weight_c;
	logic signed [AW-1:0]                 int_sum;
	logic [DW:0]                          int_c;
	logic [DW:0]                          deriv_c;
	logic [DW:0]                          drive_c;

	// symmetric clamp; returns {hit, value}
	function automatic logic [DW:0] clamp_bound(input logic signed [AW-1:0] x,
			input logic [pidf_pkg::BOUND_W-1:0] b);
		logic signed [AW-1:0] hi;
		logic signed [AW-1:0] lo;
		hi = $signed(AW'(b));
		lo = -hi;
		if (x > hi)
			return {1'b1, hi[DW-1:0]};
		else if (x < lo)
			return {1'b1, lo[DW-1:0]};
		else
			return {1'b0, x[DW-1:0]};
	endfunction

	assign weight_c  = pidf_pkg::FILTER_ONE - cfg.filter_weight;
	assign drive     = drive_q;
	assign saturated = sat_q;

	always_comb begin
		case (cmd.step)
			pidf_pkg::MS_DIFF_W: begin
				mul_a = diff_q;
				mul_b = $signed(pidf_pkg::MUL_B_W'(cfg.filter_weight));
			end
			pidf_pkg::MS_PREVD_WC: begin
				mul_a = pidf_pkg::MUL_A_W'(prev_d_q);
				mul_b = $signed(pidf_pkg::MUL_B_W'(weight_c));
			end
			pidf_pkg::MS_ERR_PLO: begin
				mul_a = pidf_pkg::MUL_A_W'(err_q);
				mul_b = $signed(pidf_pkg::MUL_B_W'(cfg.gain_p[pidf_pkg::HALF_W-1:0]));
			end
			pidf_pkg::MS_ERR_PHI: begin
				mul_a = pidf_pkg::MUL_A_W'(err_q);
				mul_b = $signed(pidf_pkg::MUL_B_W'(
					cfg.gain_p[pidf_pkg::GAIN_W-1:pidf_pkg::HALF_W]));
			end
			pidf_pkg::MS_INT_ILO: begin
				mul_a = pidf_pkg::MUL_A_W'(integ_q);
				mul_b = $signed(pidf_pkg::MUL_B_W'(cfg.gain_i[pidf_pkg::HALF_W-1:0]));
			end
			pidf_pkg::MS_INT_IHI: begin
				mul_a = pidf_pkg::MUL_A_W'(integ_q);
				mul_b = $signed(pidf_pkg::MUL_B_W'(
					cfg.gain_i[pidf_pkg::GAIN_W-1:pidf_pkg::HALF_W]));
			end
			pidf_pkg::MS_DER_DLO: begin
				mul_a = pidf_pkg::MUL_A_W'(prev_d_q);
				mul_b = $signed(pidf_pkg::MUL_B_W'(cfg.gain_d[pidf_pkg::HALF_W-1:0]));
			end
			pidf_pkg::MS_DER_DHI: begin
				mul_a = pidf_pkg::MUL_A_W'(prev_d_q);
				mul_b = $signed(pidf_pkg::MUL_B_W'(
					cfg.gain_d[pidf_pkg::GAIN_W-1:pidf_pkg::HALF_W]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		if (shift_s1)
			addend = $signed({prod_s1, {pidf_pkg::HALF_W{1'b0}}});
		else
			addend = $signed(AW'(prod_s1));
		int_sum = $signed(AW'(integ_q)) + $signed(AW'(err_q));
		int_c   = clamp_bound(int_sum, cfg.int_bound);
		deriv_c = clamp_bound(acc_q >>> pidf_pkg::FILTER_SHIFT, cfg.deriv_bound);
		drive_c = clamp_bound(acc_q >>> pidf_pkg::FRAC_BITS, cfg.drive_bound);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
			prev_d_q   <= '0;
			int_en_q   <= 1'b0;
			acc_en_s1  <= 1'b0;
		end else begin
			acc_en_s1 <= cmd.mul;
			if (cmd.clear) begin
				integ_q    <= '0;
				prev_err_q <= '0;
				prev_d_q   <= '0;
				int_en_q   <= 1'b0;
			end else begin
				if (cmd.integ) begin
					prev_err_q <= err_q;
					if (int_en_q)
						integ_q <= $signed(int_c[DW-1:0]);
				end
				if (cmd.deriv)
					prev_d_q <= $signed(deriv_c[DW-1:0]);
				// conditional integration: hold the integral after a saturated beat
				if (cmd.drive)
					int_en_q <= !drive_c[DW];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch)
			err_q <= pidf_pkg::ERR_W'(reference) - pidf_pkg::ERR_W'(feedback);
		if (cmd.integ)
			diff_q <= pidf_pkg::DIFF_W'(err_q) - pidf_pkg::DIFF_W'(prev_err_q);
		if (cmd.mul) begin
			prod_s1  <= mul_a * mul_b;
			shift_s1 <= cmd.step inside {pidf_pkg::MS_ERR_PHI, pidf_pkg::MS_INT_IHI,
				pidf_pkg::MS_DER_DHI};
		end
		if (cmd.latch || cmd.deriv)
			acc_q <= '0;
		else if (acc_en_s1)
			acc_q <= acc_q + addend;
		if (cmd.clear) begin
			drive_q <= '0;
			sat_q   <= 1'b0;
		end else if (cmd.drive) begin
			drive_q <= $signed(drive_c[DW-1:0]);
			sat_q   <= drive_c[DW];
		end
	end

endmodule

// ----- hw/rtl/pid_controller_filtered_derivative_core.sv -----
// PID core with conditional-integration anti-windup and filtered derivative.
// Update: the integrate, multiply, wait, derivative, multiply, wait and drive
// states follow the sample beat (eight passes through the shared 34x18
// multiplier); clear goes through the clear state. One item at a time: next sample
// taken once the result is loaded; a stalled result holds back only that load.
// Async reset (arst_n low) zeroes integral, derivative history, cfg and state.
`timescale 1ns / 1ps

module pid_controller_filtered_derivative_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic                                 operation,
	input  logic signed [pidf_pkg::DATA_W-1:0]   reference,
	input  logic signed [pidf_pkg::DATA_W-1:0]   feedback,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [pidf_pkg::DATA_W-1:0]   drive,
	output logic                                 saturated,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pidf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pidf_pkg::CFG_DATA_W-1:0]      cfg_data
);

	pidf_pkg::cfg_t cfg_regs;
	pidf_pkg::cmd_t cmd;

	pidf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg_regs)
	);

	pidf_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.operation    (operation),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	pidf_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_regs),
		.cmd       (cmd),
		.reference (reference),
		.feedback  (feedback),
		.drive     (drive),
		.saturated (saturated)
	);

	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && !sample_stall) |=> sample_stall)
		else $error("core took a sample beat and stayed ready");

	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.latch, cmd.clear, cmd.integ, cmd.mul, cmd.deriv, cmd.drive}))
		else $error("overlapping datapath commands");

	a_load_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.drive || cmd.clear) |=> result_valid)
		else $error("result load did not raise result_valid");

	a_clear_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (drive == '0) && !saturated)
		else $error("clear beat produced a nonzero result");

endmodule
